/* sv/fms_pkg.sv */
package fms_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;
  // widened compare widths so config values never get truncated
  localparam int MAG_W  = COUNT_WIDTH + 16;
  localparam int ELAP_W = TIME_WIDTH + 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TIME_WIDTH-1:0]  tstamp_t;

  typedef enum logic [1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    MODE_DISABLED   = 3'd0,
    MODE_IDLE       = 3'd1,
    MODE_EXTRUDING  = 3'd2,
    MODE_RETRACTING = 3'd3,
    MODE_STALLED    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    EVT_NONE    = 3'd0,
    EVT_STALL   = 3'd1,
    EVT_IDLE    = 3'd2,
    EVT_EXTRUDE = 3'd3,
    EVT_RETRACT = 3'd4
  } evt_t;

  typedef enum logic [1:0] {
    DIR_NONE    = 2'd0,
    DIR_EXTRUDE = 2'd1,
    DIR_RETRACT = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    CFG_REVERSE_DIRECTION = 3'd0,
    CFG_TICK_TOLERANCE    = 3'd1,
    CFG_STALL_TIMEOUT_MS  = 3'd2,
    CFG_STALL_REPEAT_MS   = 3'd3,
    CFG_IDLE_TIMEOUT_MS   = 3'd4,
    CFG_ENABLE_INPUT_USED = 3'd5,
    CFG_ENABLED_LEVEL     = 3'd6,
    CFG_STALLED_LEVEL     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        reverse_direction;
    logic [15:0] tick_tolerance;
    logic [31:0] stall_timeout_ms;
    logic [30:0] stall_repeat_ms;
    logic [31:0] idle_timeout_ms;
    logic        enable_input_used;
    logic        enabled_level;
    logic        stalled_level;
  } cfg_t;

  typedef struct packed {
    mode_t   mode;
    dir_t    last_dir;
    count_t  last_count;
    count_t  zero_base;
    tstamp_t last_motion_ms;
    tstamp_t last_stall_ms;
    logic    stall_asserted;
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        now_ms;
    logic signed [31:0] raw_count;
    logic               enable_pin_level;
  } in_item_t;

  typedef struct packed {
    mode_t              mode_code;
    evt_t               event_code;
    logic               direction_changed;
    logic signed [31:0] reported_count;
    logic               stall_pin_level;
  } out_item_t;

endpackage

/* sv/fms_if.sv */
interface fms_in_if import fms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        now_ms;
  logic signed [31:0] raw_count;
  logic               enable_pin_level;

  modport source (output valid, req_type, now_ms, raw_count, enable_pin_level,
                  input ready);
  modport sink (input valid, req_type, now_ms, raw_count, enable_pin_level,
                output ready);
endinterface

interface fms_out_if import fms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         mode_code;
  logic [2:0]         event_code;
  logic               direction_changed;
  logic signed [31:0] reported_count;
  logic               stall_pin_level;

  modport source (output valid, mode_code, event_code, direction_changed,
                  reported_count, stall_pin_level, input ready);
  modport sink (input valid, mode_code, event_code, direction_changed,
                reported_count, stall_pin_level, output ready);
endinterface

/* sv/fms_step.sv */
module fms_step import fms_pkg::*; (
  input  cfg_t      cfg,
  input  state_t    cur,
  input  in_item_t  item,
  output state_t    nxt,
  output out_item_t res
);

  count_t  raw_c;
  count_t  rel_c;
  count_t  diff_c;
  count_t  mag_c;
  logic    neg;
  tstamp_t now_t;
  tstamp_t motion_t;
  mode_t   mode_v;
  logic    pin_blocks;
  logic    within_tol;
  logic    past_stall;
  logic    past_idle;
  logic    past_repeat;
  evt_t    evt_v;
  logic    changed_v;
  count_t  report_c;

  always_comb begin
    raw_c       = count_t'(item.raw_count);
    now_t       = tstamp_t'(item.now_ms);
    pin_blocks  = cfg.enable_input_used && (item.enable_pin_level != cfg.enabled_level);

    rel_c = raw_c - cur.zero_base;
    if (cfg.reverse_direction) begin
      rel_c = count_t'(0) - rel_c;
    end
    diff_c     = rel_c - cur.last_count;
    neg        = diff_c[COUNT_WIDTH-1];
    mag_c      = neg ? (count_t'(0) - diff_c) : diff_c;
    within_tol = MAG_W'(mag_c) <= MAG_W'(cfg.tick_tolerance);

    nxt       = cur;
    evt_v     = EVT_NONE;
    changed_v = 1'b0;
    report_c  = '0;
    mode_v    = cur.mode;
    motion_t  = cur.last_motion_ms;
    if (mode_v == MODE_DISABLED && cfg.enable_input_used &&
        item.enable_pin_level == cfg.enabled_level) begin
      motion_t = now_t;
      mode_v   = MODE_IDLE;
    end
    past_stall  = ELAP_W'(tstamp_t'(now_t - motion_t)) > ELAP_W'(cfg.stall_timeout_ms);
    past_idle   = ELAP_W'(tstamp_t'(now_t - motion_t)) > ELAP_W'(cfg.idle_timeout_ms);
    past_repeat = (cfg.stall_repeat_ms != '0) &&
                  (ELAP_W'(tstamp_t'(now_t - cur.last_stall_ms)) >
                   ELAP_W'(cfg.stall_repeat_ms));

    case (req_t'(item.req_type))
      REQ_ENABLE: begin
        if (pin_blocks) begin
          nxt.mode           = MODE_DISABLED;
          nxt.stall_asserted = 1'b0;
        end else begin
          nxt.mode           = MODE_IDLE;
          nxt.last_motion_ms = now_t;
        end
      end
      REQ_DISABLE: begin
        nxt.mode           = MODE_DISABLED;
        nxt.stall_asserted = 1'b0;
      end
      REQ_UPDATE: begin
        if (mode_v == MODE_DISABLED || pin_blocks) begin
          mode_v = MODE_DISABLED;
        end else if (past_stall) begin
          if (mode_v != MODE_STALLED || past_repeat) begin
            mode_v             = MODE_STALLED;
            nxt.stall_asserted = 1'b1;
            nxt.last_stall_ms  = now_t;
            evt_v              = EVT_STALL;
          end
        end else if (mode_v != MODE_IDLE && within_tol && past_idle) begin
          mode_v = MODE_IDLE;
          evt_v  = EVT_IDLE;
        end else if (!within_tol) begin
          mode_v   = neg ? MODE_RETRACTING : MODE_EXTRUDING;
          motion_t = now_t;
          // reversal: re-zero relative count at the raw position
          if (cur.last_dir == (neg ? DIR_EXTRUDE : DIR_RETRACT)) begin
            nxt.zero_base = raw_c;
            rel_c         = '0;
            changed_v     = 1'b1;
          end
          nxt.last_dir   = neg ? DIR_RETRACT : DIR_EXTRUDE;
          nxt.last_count = rel_c;
          evt_v          = neg ? EVT_RETRACT : EVT_EXTRUDE;
          report_c       = rel_c;
        end
        nxt.mode           = mode_v;
        nxt.last_motion_ms = motion_t;
      end
      default: begin
      end
    endcase

    res.mode_code         = nxt.mode;
    res.event_code        = evt_v;
    res.direction_changed = changed_v;
    res.reported_count    = 32'($signed(report_c));
    res.stall_pin_level   = nxt.stall_asserted ? cfg.stalled_level : ~cfg.stalled_level;
  end

endmodule

/* sv/filament_motion_stall_monitor.sv */
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      req_type, now_ms, raw_count, enable_pin_level
// out_ch    out  valid/ready      mode_code, event_code, direction_changed,
//                                 reported_count, stall_pin_level
// cfg       in   cfg_we           cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ch.ready stays high; each
// result reaches out_ch through the input register, then the result register.
// State update and result are computed in one pass from the input register.
// Synchronous active-low reset clears mode and history and loads the default
// configuration.
// A stalled output holds the result register; the input register fills
// behind it, and in_ch.ready drops only when both are occupied.
module filament_motion_stall_monitor import fms_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  fms_in_if.sink       in_ch,
  fms_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  cfg_t      cfg_r;
  state_t    state_r;
  state_t    state_nxt;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      out_valid_r;
  logic      adv;
  logic      in_fire;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  fms_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt),
    .res  (out_item_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{mode: MODE_DISABLED, last_dir: DIR_NONE, default: '0};
      cfg_r       <= '{tick_tolerance: 16'd2, stall_timeout_ms: 32'd5000,
                       idle_timeout_ms: 32'd1000, stalled_level: 1'b1, default: '0};
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REVERSE_DIRECTION: cfg_r.reverse_direction <= cfg_wdata[0];
          CFG_TICK_TOLERANCE:    cfg_r.tick_tolerance    <= cfg_wdata[15:0];
          CFG_STALL_TIMEOUT_MS:  cfg_r.stall_timeout_ms  <= cfg_wdata;
          CFG_STALL_REPEAT_MS:   cfg_r.stall_repeat_ms   <= cfg_wdata[30:0];
          CFG_IDLE_TIMEOUT_MS:   cfg_r.idle_timeout_ms   <= cfg_wdata;
          CFG_ENABLE_INPUT_USED: cfg_r.enable_input_used <= cfg_wdata[0];
          CFG_ENABLED_LEVEL:     cfg_r.enabled_level     <= cfg_wdata[0];
          CFG_STALLED_LEVEL:     cfg_r.stalled_level     <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{req_type: in_ch.req_type, now_ms: in_ch.now_ms,
                     raw_count: in_ch.raw_count,
                     enable_pin_level: in_ch.enable_pin_level};
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.mode_code         = out_item_r.mode_code;
  assign out_ch.event_code        = out_item_r.event_code;
  assign out_ch.direction_changed = out_item_r.direction_changed;
  assign out_ch.reported_count    = out_item_r.reported_count;
  assign out_ch.stall_pin_level   = out_item_r.stall_pin_level;

  a_stall_evt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.event_code == EVT_STALL |->
      out_item_r.mode_code == MODE_STALLED &&
      out_item_r.stall_pin_level == cfg_r.stalled_level)
    else $error("stall event without stalled mode or asserted pin");

  a_rezero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.direction_changed |->
      out_item_r.reported_count == '0 &&
      (out_item_r.event_code == EVT_EXTRUDE || out_item_r.event_code == EVT_RETRACT))
    else $error("direction change without re-zeroed motion event");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost a waiting transaction");

  a_mode_sync : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && out_item_r.mode_code == state_r.mode)
    else $error("result mode differs from stored mode");

endmodule

/* dv/filament_motion_stall_monitor_tb.sv */
`timescale 1ns / 1ps

module filament_motion_stall_monitor_tb;
  import fms_pkg::*;

  // request code that the block must ignore
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  fms_in_if  in_ch ();
  fms_out_if out_ch ();

  filament_motion_stall_monitor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t        regs;
  state_t      trk;
  in_item_t    pending_samples[$];
  out_item_t   due_reports[$];
  in_item_t    nxt_item;
  in_item_t    seen_item;
  out_item_t   want;
  logic        in_took;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          err_count;
  tstamp_t     gen_ms;
  count_t      gen_pos;
  logic        gen_back;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** filament_motion_stall_monitor: FAILED **");
    $finish;
  end

  // Expected out_ch result for one request; updates the tracked state.
  function automatic out_item_t track_filament(in_item_t it);
    out_item_t r;
    count_t    cur;
    count_t    d;
    count_t    mag;
    logic      neg;
    logic      blocked;
    tstamp_t   quiet;
    tstamp_t   since_stall;
    r = '0;
    blocked = regs.enable_input_used && (it.enable_pin_level != regs.enabled_level);
    case (it.req_type)
      REQ_ENABLE: begin
        if (blocked) begin
          trk.mode = MODE_DISABLED;
          trk.stall_asserted = 1'b0;
        end else begin
          trk.last_motion_ms = it.now_ms;
          trk.mode = MODE_IDLE;
        end
      end
      REQ_DISABLE: begin
        trk.mode = MODE_DISABLED;
        trk.stall_asserted = 1'b0;
      end
      REQ_UPDATE: begin
        if (trk.mode == MODE_DISABLED && regs.enable_input_used &&
            it.enable_pin_level == regs.enabled_level) begin
          trk.last_motion_ms = it.now_ms;
          trk.mode = MODE_IDLE;
        end
        quiet = it.now_ms - trk.last_motion_ms;
        since_stall = it.now_ms - trk.last_stall_ms;
        if (trk.mode == MODE_DISABLED || blocked) begin
          // pin gate keeps the stall pin as it is
          trk.mode = MODE_DISABLED;
        end else if (quiet > regs.stall_timeout_ms) begin
          if (trk.mode != MODE_STALLED ||
              (regs.stall_repeat_ms != '0 && since_stall > regs.stall_repeat_ms)) begin
            trk.mode = MODE_STALLED;
            trk.stall_asserted = 1'b1;
            trk.last_stall_ms = it.now_ms;
            r.event_code = EVT_STALL;
          end
        end else begin
          cur = it.raw_count - trk.zero_base;
          if (regs.reverse_direction) cur = -cur;
          d = cur - trk.last_count;
          neg = d[COUNT_WIDTH-1];
          mag = neg ? -d : d;
          if (trk.mode != MODE_IDLE && mag <= regs.tick_tolerance &&
              quiet > regs.idle_timeout_ms) begin
            trk.mode = MODE_IDLE;
            r.event_code = EVT_IDLE;
          end else if (mag > regs.tick_tolerance) begin
            trk.mode = neg ? MODE_RETRACTING : MODE_EXTRUDING;
            trk.last_motion_ms = it.now_ms;
            // reversal: re-zero at the raw position
            if (trk.last_dir == (neg ? DIR_EXTRUDE : DIR_RETRACT)) begin
              trk.zero_base = it.raw_count;
              cur = '0;
              r.direction_changed = 1'b1;
            end
            trk.last_dir = neg ? DIR_RETRACT : DIR_EXTRUDE;
            trk.last_count = cur;
            r.event_code = neg ? EVT_RETRACT : EVT_EXTRUDE;
            r.reported_count = cur;
          end
        end
      end
      default: ;
    endcase
    r.mode_code = trk.mode;
    r.stall_pin_level = trk.stall_asserted ? regs.stalled_level : ~regs.stalled_level;
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      err_count++;
    end
  endfunction

  function automatic logic pin_sample();
    if (regs.enable_input_used)
      return ($urandom_range(0, 9) == 0) ? ~regs.enabled_level : regs.enabled_level;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic queue_item(logic [1:0] req, tstamp_t now, count_t raw, logic pin);
    in_item_t it;
    it.req_type = req;
    it.now_ms = now;
    it.raw_count = raw;
    it.enable_pin_level = pin;
    pending_samples.push_back(it);
  endtask

  // Mostly plausible motion traces; a few garbage and out-of-order requests.
  task automatic gen_traffic(int n);
    int unsigned pick;
    int unsigned delta;
    int unsigned tol;
    for (int i = 0; i < n; i++) begin
      tol = regs.tick_tolerance;
      pick = (i == 0) ? 8 : $urandom_range(0, 99);
      if (pick < 6) begin
        queue_item(2'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 12) begin
        gen_ms = gen_ms + $urandom_range(0, 300);
        queue_item(REQ_ENABLE, gen_ms, gen_pos, pin_sample());
      end else if (pick < 15) begin
        queue_item(REQ_DISABLE, gen_ms, gen_pos, pin_sample());
      end else if (pick < 17) begin
        queue_item(REQ_UNKNOWN, gen_ms, gen_pos, pin_sample());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          gen_ms = gen_ms + $urandom_range(0, 300);
        else if (pick < 85)
          gen_ms = gen_ms + regs.idle_timeout_ms - 20 + $urandom_range(0, 40);
        else
          gen_ms = gen_ms + regs.stall_timeout_ms - 20 + $urandom_range(0, 40);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          delta = $urandom_range(0, tol);
          if ($urandom_range(0, 1)) delta = -delta;
        end else begin
          if (pick >= 85) gen_back = ~gen_back;
          delta = tol + 1 + $urandom_range(0, 60);
          if (gen_back) delta = -delta;
        end
        gen_pos = gen_pos + delta;
        queue_item(REQ_UPDATE, gen_ms, gen_pos, pin_sample());
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_ch.valid || due_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REVERSE_DIRECTION: regs.reverse_direction = val[0];
      CFG_TICK_TOLERANCE:    regs.tick_tolerance = val[15:0];
      CFG_STALL_TIMEOUT_MS:  regs.stall_timeout_ms = val;
      CFG_STALL_REPEAT_MS:   regs.stall_repeat_ms = val[30:0];
      CFG_IDLE_TIMEOUT_MS:   regs.idle_timeout_ms = val;
      CFG_ENABLE_INPUT_USED: regs.enable_input_used = val[0];
      CFG_ENABLED_LEVEL:     regs.enabled_level = val[0];
      CFG_STALLED_LEVEL:     regs.stalled_level = val[0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic rev, logic [15:0] tol, logic [31:0] stall_ms,
                           logic [30:0] rpt_ms, logic [31:0] idle_ms, logic pin_used,
                           logic pin_level, logic stall_level);
    write_reg(CFG_REVERSE_DIRECTION, rev);
    write_reg(CFG_TICK_TOLERANCE, tol);
    write_reg(CFG_STALL_TIMEOUT_MS, stall_ms);
    write_reg(CFG_STALL_REPEAT_MS, rpt_ms);
    write_reg(CFG_IDLE_TIMEOUT_MS, idle_ms);
    write_reg(CFG_ENABLE_INPUT_USED, pin_used);
    write_reg(CFG_ENABLED_LEVEL, pin_level);
    write_reg(CFG_STALLED_LEVEL, stall_level);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: hold the current transaction until taken, then maybe idle.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_took) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt_item = pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= nxt_item.req_type;
          in_ch.now_ms <= nxt_item.now_ms;
          in_ch.raw_count <= nxt_item.raw_count;
          in_ch.enable_pin_level <= nxt_item.enable_pin_level;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: check results, then predict for the transaction taken this edge.
  always @(posedge clk) begin
    in_took = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_reports.size() == 0) begin
        $error("unexpected result: mode %0d event %0d count 0x%0h",
               out_ch.mode_code, out_ch.event_code, out_ch.reported_count);
        err_count++;
      end else begin
        want = due_reports.pop_front();
        cmp_field("mode_code", want.mode_code, out_ch.mode_code);
        cmp_field("event_code", want.event_code, out_ch.event_code);
        cmp_field("direction_changed", want.direction_changed, out_ch.direction_changed);
        cmp_field("reported_count", want.reported_count, out_ch.reported_count);
        cmp_field("stall_pin_level", want.stall_pin_level, out_ch.stall_pin_level);
      end
    end
    if (in_took) begin
      seen_item.req_type = in_ch.req_type;
      seen_item.now_ms = in_ch.now_ms;
      seen_item.raw_count = in_ch.raw_count;
      seen_item.enable_pin_level = in_ch.enable_pin_level;
      due_reports.push_back(track_filament(seen_item));
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_UPDATE;
    in_ch.now_ms = '0;
    in_ch.raw_count = '0;
    in_ch.enable_pin_level = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REVERSE_DIRECTION;
    cfg_wdata = '0;
    rst_n = 1'b0;
    in_took = 1'b0;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gen_back = 1'b0;
    trk = '0;
    regs.reverse_direction = 1'b0;
    regs.tick_tolerance = 16'd2;
    regs.stall_timeout_ms = 32'd5000;
    regs.stall_repeat_ms = '0;
    regs.idle_timeout_ms = 32'd1000;
    regs.enable_input_used = 1'b0;
    regs.enabled_level = 1'b0;
    regs.stalled_level = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: walk through every mode by hand
    queue_item(REQ_UPDATE, 32'd100, 32'd0, 1'b0);
    queue_item(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    queue_item(REQ_ENABLE, 32'd100, 32'd0, 1'b1);
    queue_item(REQ_UPDATE, 32'd200, 32'd2, 1'b0);
    queue_item(REQ_UPDATE, 32'd300, 32'd3, 1'b1);
    queue_item(REQ_UPDATE, 32'd400, 32'd40, 1'b0);
    queue_item(REQ_UPDATE, 32'd500, 32'd30, 1'b0);
    queue_item(REQ_UPDATE, 32'd600, 32'd10, 1'b0);
    queue_item(REQ_UPDATE, 32'd1601, 32'd10, 1'b0);
    queue_item(REQ_UPDATE, 32'd5600, 32'd11, 1'b0);
    queue_item(REQ_UPDATE, 32'd5601, 32'd11, 1'b0);
    queue_item(REQ_UPDATE, 32'd9000, 32'd500, 1'b0);
    queue_item(REQ_ENABLE, 32'd9100, 32'd500, 1'b0);
    queue_item(REQ_UPDATE, 32'd9200, 32'h7FFF_FFFF, 1'b0);
    queue_item(REQ_UPDATE, 32'd9300, 32'h8000_0000, 1'b1);
    queue_item(REQ_UPDATE, 32'd9400, 32'hFFFF_FFFF, 1'b1);
    queue_item(REQ_DISABLE, 32'd9500, 32'd0, 1'b0);
    queue_item(REQ_ENABLE, 32'hFFFF_FF00, 32'd0, 1'b0);
    queue_item(REQ_UPDATE, 32'h0000_0100, 32'd100, 1'b1);
    queue_item(REQ_UPDATE, 32'h0000_0200, 32'hFFFF_FF00, 1'b0);
    gen_ms = 32'h0000_0300;
    gen_pos = 32'hFFFF_FF00;
    gen_traffic(80);
    wait_drained();

    load_regs(1'b1, 16'd0, 32'd300, 31'd100, 32'd50, 1'b0, 1'b0, 1'b0);
    send_idle_pct = 53;
    recv_stall_pct = 0;
    gen_traffic(80);
    wait_drained();

    load_regs(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    gen_traffic(80);
    wait_drained();

    load_regs(1'b0, 16'd5, 32'd2000, 31'd500, 32'd0, 1'b1, 1'b1, 1'b1);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    // enable pin: refused enable, wake by pin, gate while stalled
    queue_item(REQ_ENABLE, gen_ms, gen_pos, 1'b0);
    queue_item(REQ_UPDATE, gen_ms + 10, gen_pos, 1'b0);
    queue_item(REQ_UPDATE, gen_ms + 20, gen_pos, 1'b1);
    queue_item(REQ_UPDATE, gen_ms + 3000, gen_pos, 1'b1);
    queue_item(REQ_UPDATE, gen_ms + 3100, gen_pos, 1'b0);
    queue_item(REQ_UPDATE, gen_ms + 3200, gen_pos, 1'b1);
    queue_item(REQ_UPDATE, gen_ms + 3300, gen_pos + 100, 1'b1);
    queue_item(REQ_UPDATE, gen_ms + 3301, gen_pos + 100, 1'b1);
    gen_ms = gen_ms + 3400;
    gen_pos = gen_pos + 100;
    gen_traffic(80);
    wait_drained();

    load_regs(1'b1, 16'd3, 32'd0, 31'd1, 32'd0, 1'b1, 1'b0, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gen_traffic(40);
    // hold off the sender until every result is back
    wait_drained();
    gen_traffic(40);
    wait_drained();

    load_regs(1'b1, 16'd2, 32'd1500, 31'd0, 32'd400, 1'b0, 1'b0, 1'b1);
    send_idle_pct = 53;
    recv_stall_pct = 0;
    gen_traffic(80);
    wait_drained();

    load_regs(1'b0, 16'd10, 32'd800, 31'd200, 32'd100, 1'b0, 1'b1, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    gen_traffic(80);
    wait_drained();

    load_regs(1'b0, 16'd2, 32'd5000, 31'd0, 32'd1000, 1'b0, 1'b0, 1'b1);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    gen_traffic(80);
    wait_drained();
    repeat (8) @(posedge clk);

    if (err_count == 0)
      $display("** filament_motion_stall_monitor: PASSED **");
    else
      $display("** filament_motion_stall_monitor: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
sv/fms_pkg.sv
sv/fms_if.sv
sv/fms_step.sv
sv/filament_motion_stall_monitor.sv
dv/filament_motion_stall_monitor_tb.sv
